/* hdl/pole_pkg.sv */
// Package for the positional ordered list engine.
// Holds capacity, widths, command and status codes, and the sequencer state type.
package pole_pkg;
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IW         = $clog2(CAPACITY);
  localparam int CW         = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_INS_AT    = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,   // reset sweep of the link memory
    S_IDLE,
    S_WALK,   // issue read of link at ptr
    S_WAITW,  // link data arrives
    S_FREE,   // read link of free head
    S_FREEW,
    S_VICT,   // read link of ptr, or of victim for del_front
    S_VICTW,
    S_SKIP,   // del_at: read link of victim
    S_SKIPW,  // del_at: relink predecessor past victim
    S_REL,    // del_at: return victim to free list
    S_DREAD,  // dump: read data and link of ptr
    S_DOUT,   // dump: present beat
    S_RESP
  } state_t;
endpackage

/* hdl/pole_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module pole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* hdl/positional_ordered_list_engine.sv */
// Top level of the positional ordered list engine: sequencer over link and data RAMs.
// Depends on pole_pkg and pole_ram.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: cmd[2:0], position[10:3], value[42:11]
// m_axis  | out | tdata: status[1:0], count[6:2], element[38:7]; tlast: last
//
// After reset a sweep links each entry to the next; no beat is taken during it.
// Front and back inserts and front deletes need no walk; positional commands and
// back deletes walk the links from the head, and a dump reads one element per link.
// One command at a time; a result held by m_axis_tready stalls the sequencer.
module positional_ordered_list_engine import pole_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // cmd, position, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status, count, element
  output logic        m_axis_tlast   // last
);
  state_t state, state_next;
  cmd_t cmd, cmd_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  logic [IW-1:0] head, head_next, tail, tail_next, fhead, fhead_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [IW-1:0] ptr, ptr_next, nn, nn_next, vic, vic_next;
  logic [CW-1:0] steps, steps_next;
  logic [1:0] st, st_next;
  logic [DATA_WIDTH-1:0] elem, elem_next;
  logic lst, lst_next;
  logic [IW-1:0] sweep, sweep_next;

  logic          l_we, d_we;
  logic [IW-1:0] l_addr, d_addr, l_wd, l_rd;
  logic [DATA_WIDTH-1:0] d_rd;

  pole_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
  pole_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(val), .rdata(d_rd));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_RESP) || (state == S_DOUT);
  assign m_axis_tdata  = {1'b0, (state == S_DOUT) ? d_rd : elem, cnt, st};
  assign m_axis_tlast  = lst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      head  <= '0;
      tail  <= '0;
      fhead <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      head  <= head_next;
      tail  <= tail_next;
      fhead <= fhead_next;
      cnt   <= cnt_next;
    end
    cmd <= cmd_next; val <= val_next;
    ptr <= ptr_next; nn <= nn_next; vic <= vic_next; steps <= steps_next;
    st <= st_next; elem <= elem_next; lst <= lst_next;
  end

  always_comb begin
    state_next = state; sweep_next = sweep;
    head_next = head; tail_next = tail; fhead_next = fhead; cnt_next = cnt;
    cmd_next = cmd; val_next = val;
    ptr_next = ptr; nn_next = nn; vic_next = vic; steps_next = steps;
    st_next = st; elem_next = elem; lst_next = lst;
    l_we = 1'b0; l_addr = ptr; l_wd = '0;
    d_we = 1'b0; d_addr = ptr;
    unique case (state)
      S_INIT: begin
        l_we = 1'b1; l_addr = sweep; l_wd = sweep + IW'(1);
        sweep_next = sweep + IW'(1);
        if (sweep == IW'(CAPACITY - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_next = cmd_t'(s_axis_tdata[2:0]);
          val_next = s_axis_tdata[11 +: DATA_WIDTH];
          elem_next = '0; lst_next = 1'b1; st_next = ST_OK;
          state_next = S_RESP;
          ptr_next = head;
          unique case (cmd_t'(s_axis_tdata[2:0]))
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (cnt == CW'(CAPACITY)) st_next = ST_FULL;
              else begin
                steps_next = '0; state_next = S_FREE;
              end
            end
            CMD_DEL_FRONT: begin
              if (cnt == '0) st_next = ST_EMPTY;
              else begin
                vic_next = head; state_next = S_VICT; steps_next = '0;
              end
            end
            CMD_DEL_BACK: begin
              if (cnt == '0) st_next = ST_EMPTY;
              else if (cnt == CW'(1)) begin
                cmd_next = CMD_DEL_FRONT; vic_next = head; state_next = S_VICT;
              end else begin
                steps_next = cnt - CW'(2); vic_next = tail;
                state_next = (cnt == CW'(2)) ? S_VICT : S_WALK;
              end
            end
            CMD_INS_AT: begin
              if (s_axis_tdata[10:3] == 8'd0 || {1'b0, s_axis_tdata[10:3]} > 9'(cnt) + 9'd1)
                st_next = ST_BADPOS;
              else if (cnt == CW'(CAPACITY)) st_next = ST_FULL;
              else begin
                if (s_axis_tdata[10:3] == 8'd1) cmd_next = CMD_INS_FRONT;
                else if (9'(s_axis_tdata[10:3]) == 9'(cnt) + 9'd1) cmd_next = CMD_INS_BACK;
                steps_next = CW'(s_axis_tdata[10:3] - 8'd2);
                state_next = (s_axis_tdata[10:3] == 8'd1 || s_axis_tdata[10:3] == 8'd2 ||
                              9'(s_axis_tdata[10:3]) == 9'(cnt) + 9'd1) ? S_FREE : S_WALK;
              end
            end
            CMD_DEL_AT: begin
              if (cnt == '0) st_next = ST_EMPTY;
              else if (s_axis_tdata[10:3] == 8'd0 || 9'(s_axis_tdata[10:3]) > 9'(cnt))
                st_next = ST_BADPOS;
              else if (s_axis_tdata[10:3] == 8'd1) begin
                cmd_next = CMD_DEL_FRONT; vic_next = head; state_next = S_VICT;
              end else begin
                if (9'(s_axis_tdata[10:3]) == 9'(cnt)) begin
                  cmd_next = CMD_DEL_BACK; vic_next = tail;
                end
                steps_next = CW'(s_axis_tdata[10:3] - 8'd2);
                state_next = (s_axis_tdata[10:3] == 8'd2) ? S_VICT : S_WALK;
              end
            end
            CMD_DUMP: begin
              if (cnt == '0) st_next = ST_EMPTY;
              else begin
                steps_next = '0; state_next = S_DREAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        l_addr = ptr; state_next = S_WAITW;
      end
      S_WAITW: begin
        ptr_next = l_rd; steps_next = steps - CW'(1);
        if (steps == CW'(1)) state_next = (cmd == CMD_INS_AT) ? S_FREE : S_VICT;
        else state_next = S_WALK;
      end
      S_FREE: begin
        l_addr = fhead; state_next = S_FREEW;
      end
      S_FREEW: begin
        // fhead link read; take entry fhead
        fhead_next = l_rd;
        d_we = 1'b1; d_addr = fhead;
        cnt_next = cnt + CW'(1);
        state_next = S_RESP;
        unique case (cmd)
          CMD_INS_FRONT: begin
            if (cnt != '0) begin
              l_we = 1'b1; l_addr = fhead; l_wd = head;
            end else tail_next = fhead;
            head_next = fhead;
          end
          CMD_INS_BACK: begin
            if (cnt != '0) begin
              l_we = 1'b1; l_addr = tail; l_wd = fhead;
            end else head_next = fhead;
            tail_next = fhead;
          end
          default: begin
            // middle insert after ptr: new.link = ptr.link, then ptr.link = new
            nn_next = fhead;
            cnt_next = cnt;
            d_we = 1'b1;
            state_next = S_VICT;
          end
        endcase
      end
      S_VICT: begin
        // read link of ptr (ins_at/del_at/del_back) or of victim (del_front)
        l_addr = (cmd == CMD_DEL_FRONT) ? vic : ptr;
        state_next = S_VICTW;
      end
      S_VICTW: begin
        state_next = S_RESP;
        unique case (cmd)
          CMD_DEL_FRONT: begin
            if (cnt > CW'(1)) head_next = l_rd;
            l_we = 1'b1; l_addr = vic; l_wd = fhead;
            fhead_next = vic; cnt_next = cnt - CW'(1);
          end
          CMD_DEL_BACK: begin
            tail_next = ptr;
            l_we = 1'b1; l_addr = vic; l_wd = fhead;
            fhead_next = vic; cnt_next = cnt - CW'(1);
          end
          CMD_INS_AT: begin
            // l_rd = old successor of ptr; write new.link, then ptr.link next cycle
            l_we = 1'b1; l_addr = nn; l_wd = l_rd;
            vic_next = nn; cmd_next = CMD_NONE; state_next = S_VICTW;
            cnt_next = cnt + CW'(1);
          end
          CMD_NONE: begin
            l_we = 1'b1; l_addr = ptr; l_wd = vic;
          end
          default: begin
            // del_at middle: victim = ptr.link
            vic_next = l_rd; state_next = S_SKIP;
          end
        endcase
      end
      S_SKIP: begin
        l_addr = vic; state_next = S_SKIPW;
      end
      S_SKIPW: begin
        l_we = 1'b1; l_addr = ptr; l_wd = l_rd;
        state_next = S_REL;
      end
      S_REL: begin
        l_we = 1'b1; l_addr = vic; l_wd = fhead;
        fhead_next = vic; cnt_next = cnt - CW'(1);
        state_next = S_RESP;
      end
      S_DREAD: begin
        l_addr = ptr; d_addr = ptr; state_next = S_DOUT;
        elem_next = '0;
        lst_next = (steps + CW'(1) == cnt);
      end
      S_DOUT: begin
        if (m_axis_tready) begin
          ptr_next = l_rd;
          steps_next = steps + CW'(1);
          state_next = (steps + CW'(1) == cnt) ? S_IDLE : S_DREAD;
        end
      end
      S_RESP: begin
        if (m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* hdl/pole_checker.sv */
// Port checker for the positional ordered list engine.
// Depends on pole_pkg; bound to the top level.
module pole_checker import pole_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat dropped while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[6:2] <= 5'(CAPACITY))
    else $error("count above capacity");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while result pending");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while command in flight");
endmodule

bind positional_ordered_list_engine pole_checker u_chk (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for positional_ordered_list_engine: directed table, then random commands.
// Depends on pole_pkg; predicts results with an internal linked-list model and compares beats.
module tb_top;
  import pole_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  count;
    logic [31:0] element;
    logic        last;
  } beat_t;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  position;
    logic [31:0] value;
    bit          fixed;
    logic [1:0]  status;
    logic [4:0]  count;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  positional_ordered_list_engine dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  logic [31:0] list_data [CAPACITY];
  logic [3:0]  list_link [CAPACITY];
  logic [3:0]  head_ix, tail_ix, free_ix;
  int          list_len;
  beat_t       pending_q[$];
  int          mismatches;
  int          idle_cycles;
  bit          timed_out;
  bit          sending_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] walk_links(int steps);
    logic [3:0] p;
    p = head_ix;
    for (int k = 0; k < steps; k++) p = list_link[p];
    return p;
  endfunction

  function automatic logic [3:0] grab_slot(logic [31:0] v);
    logic [3:0] n;
    n = free_ix;
    free_ix = list_link[n];
    list_data[n] = v;
    return n;
  endfunction

  function automatic void release_slot(logic [3:0] i);
    list_link[i] = free_ix;
    free_ix = i;
  endfunction

  function automatic logic [1:0] push_front(logic [31:0] v);
    logic [3:0] n;
    if (list_len >= CAPACITY) return ST_FULL;
    n = grab_slot(v);
    if (list_len == 0) tail_ix = n;
    else list_link[n] = head_ix;
    head_ix = n;
    list_len++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] push_back(logic [31:0] v);
    logic [3:0] n;
    if (list_len >= CAPACITY) return ST_FULL;
    n = grab_slot(v);
    if (list_len == 0) head_ix = n;
    else list_link[tail_ix] = n;
    tail_ix = n;
    list_len++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] pop_front();
    logic [3:0] old;
    if (list_len == 0) return ST_EMPTY;
    old = head_ix;
    if (list_len > 1) head_ix = list_link[old];
    release_slot(old);
    list_len--;
    return ST_OK;
  endfunction

  function automatic logic [1:0] pop_back();
    logic [3:0] old;
    if (list_len == 0) return ST_EMPTY;
    if (list_len == 1) return pop_front();
    old = tail_ix;
    tail_ix = walk_links(list_len - 2);
    release_slot(old);
    list_len--;
    return ST_OK;
  endfunction

  function automatic void reset_list();
    for (int i = 0; i < CAPACITY; i++) begin
      list_link[i] = 4'((i + 1) % CAPACITY);
      list_data[i] = '0;
    end
    head_ix = 0;
    tail_ix = 0;
    free_ix = 0;
    list_len = 0;
  endfunction

  function automatic void predict_list(cmd_t cmd, int pos, logic [31:0] v);
    logic [1:0] st;
    logic [3:0] pred, n, victim, p;
    st = ST_OK;
    case (cmd)
      CMD_INS_FRONT: st = push_front(v);
      CMD_INS_BACK:  st = push_back(v);
      CMD_DEL_FRONT: st = pop_front();
      CMD_DEL_BACK:  st = pop_back();
      CMD_INS_AT: begin
        if (pos < 1 || pos > list_len + 1) st = ST_BADPOS;
        else if (list_len >= CAPACITY) st = ST_FULL;
        else if (pos == 1) st = push_front(v);
        else if (pos == list_len + 1) st = push_back(v);
        else begin
          pred = walk_links(pos - 2);
          n = grab_slot(v);
          list_link[n] = list_link[pred];
          list_link[pred] = n;
          list_len++;
        end
      end
      CMD_DEL_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (pos < 1 || pos > list_len) st = ST_BADPOS;
        else if (pos == 1) st = pop_front();
        else if (pos == list_len) st = pop_back();
        else begin
          pred = walk_links(pos - 2);
          victim = list_link[pred];
          list_link[pred] = list_link[victim];
          release_slot(victim);
          list_len--;
        end
      end
      CMD_DUMP: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          p = head_ix;
          for (int k = 0; k < list_len; k++) begin
            pending_q.push_back('{ST_OK, 5'(list_len), list_data[p], k + 1 == list_len});
            p = list_link[p];
          end
          return;
        end
      end
      default: st = ST_OK;
    endcase
    pending_q.push_back('{st, 5'(list_len), 32'd0, 1'b1});
  endfunction

  task automatic send_cmd(cmd_t cmd, logic [7:0] pos, logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {5'd0, v, pos, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_list(cmd, pos, v);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) stall = ($urandom_range(0, 3) == 0) ? 0
                                                  : $urandom_range(0, 15);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[6:2], m_axis_tdata[38:7], m_axis_tlast};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d cnt=%0d el=%h last=%0d, got st=%0d cnt=%0d el=%h last=%0d",
                     want.status, want.count, want.element, want.last,
                     got.status, got.count, got.element, got.last);
        end
      end
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst
        || (sending_done && pending_q.size() == 0))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1;
      $display("Test completed with failures");
      $finish;
    end
  end

  row_t dir_rows[$];

  initial begin
    cmd_t c;
    int   r;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 0;
    sending_done = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    reset_list();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    dir_rows = '{
      '{CMD_DUMP,      8'd0,   32'h0,        1, ST_EMPTY,  5'd0},
      '{CMD_DEL_FRONT, 8'd0,   32'h0,        1, ST_EMPTY,  5'd0},
      '{CMD_DEL_BACK,  8'd0,   32'h0,        1, ST_EMPTY,  5'd0},
      '{CMD_DEL_AT,    8'd1,   32'h0,        1, ST_EMPTY,  5'd0},
      '{CMD_INS_AT,    8'd0,   32'h1,        1, ST_BADPOS, 5'd0},
      '{CMD_INS_AT,    8'd2,   32'h1,        1, ST_BADPOS, 5'd0},
      '{CMD_NONE,      8'hFF,  32'hFFFFFFFF, 1, ST_OK,     5'd0},
      '{CMD_INS_AT,    8'd1,   32'hFFFFFFFF, 1, ST_OK,     5'd1},
      '{CMD_INS_FRONT, 8'd0,   32'h00000000, 1, ST_OK,     5'd2},
      '{CMD_INS_BACK,  8'hFF,  32'hA5A5A5A5, 1, ST_OK,     5'd3},
      '{CMD_INS_AT,    8'd4,   32'h5A5A5A5A, 1, ST_OK,     5'd4},
      '{CMD_INS_AT,    8'd2,   32'h12345678, 1, ST_OK,     5'd5},
      '{CMD_DEL_AT,    8'd6,   32'h0,        1, ST_BADPOS, 5'd5},
      '{CMD_DEL_AT,    8'hFF,  32'h0,        1, ST_BADPOS, 5'd5},
      '{CMD_DUMP,      8'd0,   32'h0,        0, ST_OK,     5'd0},
      '{CMD_DEL_AT,    8'd5,   32'h0,        1, ST_OK,     5'd4},
      '{CMD_INS_BACK,  8'd0,   32'h0000BEEF, 1, ST_OK,     5'd5},
      '{CMD_DEL_AT,    8'd3,   32'h0,        1, ST_OK,     5'd4},
      '{CMD_DEL_BACK,  8'd0,   32'h0,        1, ST_OK,     5'd3},
      '{CMD_DUMP,      8'd0,   32'h0,        0, ST_OK,     5'd0}
    };
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].position, dir_rows[i].value);
      if (dir_rows[i].fixed && (pending_q[$].status !== dir_rows[i].status
                                || pending_q[$].count !== dir_rows[i].count)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: model disagrees with table", i);
      end
    end
    // fill to capacity and probe full-list cases
    while (list_len < CAPACITY) send_cmd(CMD_INS_BACK, 8'd0, $urandom());
    send_cmd(CMD_INS_FRONT, 8'd0, 32'h1);
    send_cmd(CMD_INS_AT, 8'd17, 32'h1);
    send_cmd(CMD_INS_AT, 8'd3, 32'h1);
    send_cmd(CMD_DUMP, 8'd0, 32'h0);
    drain_results();

    for (int n = 0; n < 330; n++) begin
      r = $urandom_range(0, 99);
      if (r < 18)      c = CMD_INS_AT;
      else if (r < 34) c = CMD_DEL_AT;
      else if (r < 46) c = CMD_INS_FRONT;
      else if (r < 58) c = CMD_INS_BACK;
      else if (r < 68) c = CMD_DEL_FRONT;
      else if (r < 80) c = CMD_DEL_BACK;
      else if (r < 94) c = CMD_DUMP;
      else             c = CMD_NONE;
      if ($urandom_range(0, 9) == 0)
        send_cmd(c, 8'($urandom()), $urandom());
      else
        send_cmd(c, 8'($urandom_range(0, list_len + 2)), $urandom());
      if (n == 160) drain_results();
    end
    drain_results();
    sending_done = 1;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
